// File: src/wrep_pkg.sv
// Shared types and constants of the weighted random entry picker.
package wrep_pkg;

	localparam int MOVE_W          = 16;
	localparam int SCORE_IN_W      = 16;
	localparam int SCORE_W         = 15;
	localparam int RND_W           = 32;
	localparam int MAX_ENTRIES_DEF = 64;

	typedef struct packed {
		logic [MOVE_W-1:0]  move_code;
		logic [SCORE_W-1:0] score;
		logic               keep;
		logic               last;
		logic [RND_W-1:0]   random_value;
	} cand_t;

endpackage

// File: src/wrep_if.sv
// Stream interfaces for candidate beats and result beats.
interface wrep_in_if;
	import wrep_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [MOVE_W-1:0]      move_code;
	logic signed [SCORE_IN_W-1:0] score;
	logic                   valid_mark;
	logic                   last;
	logic [RND_W-1:0]       random_value;

	modport source (output valid, move_code, score, valid_mark, last, random_value,
		input ready);
	modport sink (input valid, move_code, score, valid_mark, last, random_value,
		output ready);
endinterface

interface wrep_out_if;
	import wrep_pkg::*;
	logic              valid;
	logic              ready;
	logic              found;
	logic [MOVE_W-1:0] chosen_move;
	logic              overflowed;

	modport source (output valid, found, chosen_move, overflowed, input ready);
	modport sink (input valid, found, chosen_move, overflowed, output ready);
endinterface

// File: src/weighted_random_entry_picker.sv
// Top level of the weighted random entry picker.
//
//   channel  dir  beat                                                 when
//   cfg      in   pick_mode                                            cfg_we high
//   in_ch    in   move_code, score, valid_mark, last, random_value     valid && ready
//   out_ch   out  found, chosen_move, overflowed                       valid && ready
//
// The back end takes a candidate beat whenever it is idle; a two-deep queue parts front and back.
// A last beat reaches the result register through the total state, the divider start, the
// 32 remainder steps in the divider, then one memory read and one compare per entry
// scanned up to the pick. An empty set skips the divider and the scan.
// Reset clears the set, the queue and the output valid flag; the entry memory is not cleared.
// A waiting result beat stalls the back end only when the next result is ready.
module weighted_random_entry_picker import wrep_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	wrep_in_if.sink     in_ch,
	wrep_out_if.source  out_ch
);

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int TOT_W = SCORE_W + CNT_W;

	logic             mode_q;
	logic             q_valid;
	logic             q_pop;
	cand_t            q_data;
	logic             div_start;
	logic [RND_W-1:0] div_dividend;
	logic [TOT_W-1:0] div_divisor;
	logic             div_done;
	logic [TOT_W-1:0] div_rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	wrep_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_data  (q_data)
	);

	wrep_mod #(
		.TOT_W (TOT_W)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	wrep_back #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.CNT_W       (CNT_W),
		.TOT_W       (TOT_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pick_mode    (mode_q),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_data       (q_data),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_rem      (div_rem),
		.out_ch       (out_ch)
	);

endmodule

// File: src/wrep_front.sv
// Front end: accept candidate beats, classify them, queue them for the back end.
module wrep_front import wrep_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	wrep_in_if.sink in_ch,
	output logic    q_valid,
	input  logic    q_pop,
	output cand_t   q_data
);

	cand_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        push;
	cand_t       cand;

	assign in_ch.ready = (fill_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (fill_q != 2'd0);
	assign q_data      = slot_q[rd_ptr_q];

	always_comb begin
		cand.move_code    = in_ch.move_code;
		cand.score        = in_ch.score[SCORE_W-1:0];
		cand.keep         = in_ch.valid_mark && !in_ch.score[SCORE_IN_W-1]
			&& (in_ch.score != '0);
		cand.last         = in_ch.last;
		cand.random_value = in_ch.random_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// File: src/wrep_mod.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
module wrep_mod import wrep_pkg::*; #(
	parameter int TOT_W = 21
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] dividend,
	input  logic [TOT_W-1:0] divisor,
	output logic             done,
	output logic [TOT_W-1:0] remainder
);

	localparam int STEP_W = $clog2(RND_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0]  dvd_q;
	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W-1:0]  dsr_q;
	logic [TOT_W:0]    trial;
	logic              fits;

	assign trial     = {rem_q, dvd_q[RND_W-1]};
	assign fits      = (trial >= {1'b0, dsr_q});
	assign done      = done_q;
	assign remainder = rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			rem_q <= fits ? TOT_W'(trial - {1'b0, dsr_q}) : trial[TOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == STEP_W'(RND_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(RND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// File: src/wrep_back.sv
// Back end: store kept entries, run the pick on the last beat, hold the result beat.
module wrep_back import wrep_pkg::*; #(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
	parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
	parameter int TOT_W       = SCORE_W + CNT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pick_mode,
	input  logic              q_valid,
	output logic              q_pop,
	input  cand_t             q_data,
	output logic              div_start,
	output logic [RND_W-1:0]  div_dividend,
	output logic [TOT_W-1:0]  div_divisor,
	input  logic              div_done,
	input  logic [TOT_W-1:0]  div_rem,
	wrep_out_if.source        out_ch
);

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	localparam logic [2:0] B_IDLE  = 3'd0;
	localparam logic [2:0] B_TOT   = 3'd1;
	localparam logic [2:0] B_START = 3'd2;
	localparam logic [2:0] B_DIV   = 3'd3;
	localparam logic [2:0] B_RD    = 3'd4;
	localparam logic [2:0] B_CMP   = 3'd5;
	localparam logic [2:0] B_OUT   = 3'd6;

	logic [MOVE_W+SCORE_W-1:0] mem [MAX_ENTRIES];
	logic [MOVE_W+SCORE_W-1:0] rd_q;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [TOT_W-1:0]   total_q;
	logic [SCORE_W-1:0] top_q;
	logic [CNT_W-1:0]   tcnt_q;
	logic               drop_q;
	logic [RND_W-1:0]   rnd_q;
	logic [TOT_W-1:0]   tot_q;
	logic [TOT_W-1:0]   pick_q;
	logic [TOT_W-1:0]   run_q;
	logic [IDX_W-1:0]   idx_q;
	logic               found_q;
	logic [MOVE_W-1:0]  move_q;

	logic               out_v_q;
	logic               out_found_q;
	logic [MOVE_W-1:0]  out_move_q;
	logic               out_ovf_q;

	logic               take;
	logic               room;
	logic               wr_en;
	logic [SCORE_W-1:0] rd_score;
	logic [MOVE_W-1:0]  rd_move;
	logic               use_entry;
	logic [TOT_W-1:0]   run_nx;
	logic               out_load;

	assign q_pop        = (state_q == B_IDLE) && q_valid;
	assign take         = q_pop;
	assign room         = (cnt_q != CNT_W'(MAX_ENTRIES));
	assign wr_en        = take && q_data.keep && room;
	assign div_start    = (state_q == B_START);
	assign div_dividend = rnd_q;
	assign div_divisor  = tot_q;
	assign rd_move      = rd_q[MOVE_W+SCORE_W-1:SCORE_W];
	assign rd_score     = rd_q[SCORE_W-1:0];
	assign use_entry    = !pick_mode || (rd_score == top_q);
	assign run_nx       = run_q + (use_entry ? TOT_W'(rd_score) : '0);
	assign out_load     = (state_q == B_OUT) && (!out_v_q || out_ch.ready);

	assign out_ch.valid       = out_v_q;
	assign out_ch.found       = out_found_q;
	assign out_ch.chosen_move = out_move_q;
	assign out_ch.overflowed  = out_ovf_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= {q_data.move_code, q_data.score};
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (take && q_data.last) begin
			rnd_q <= q_data.random_value;
		end
		if (state_q == B_TOT) begin
			tot_q <= pick_mode ? TOT_W'(top_q) * TOT_W'(tcnt_q) : total_q;
		end
		if (state_q == B_DIV && div_done) begin
			pick_q <= div_rem;
		end
		if (out_load) begin
			out_found_q <= found_q;
			out_move_q  <= found_q ? move_q : '0;
			out_ovf_q   <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			total_q <= '0;
			top_q   <= '0;
			tcnt_q  <= '0;
			drop_q  <= 1'b0;
			run_q   <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
			move_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (take) begin
						if (q_data.keep) begin
							if (!room) begin
								drop_q <= 1'b1;
							end else begin
								cnt_q   <= cnt_q + CNT_W'(1);
								total_q <= total_q + TOT_W'(q_data.score);
								if (q_data.score > top_q) begin
									top_q  <= q_data.score;
									tcnt_q <= CNT_W'(1);
								end else if (q_data.score == top_q) begin
									tcnt_q <= tcnt_q + CNT_W'(1);
								end
							end
						end
						if (q_data.last) begin
							state_q <= B_TOT;
						end
					end
				end
				B_TOT: begin
					found_q <= 1'b0;
					run_q   <= '0;
					idx_q   <= '0;
					state_q <= (cnt_q == '0) ? B_OUT : B_START;
				end
				B_START: begin
					state_q <= B_DIV;
				end
				B_DIV: begin
					if (div_done) begin
						state_q <= B_RD;
					end
				end
				B_RD: begin
					state_q <= B_CMP;
				end
				B_CMP: begin
					run_q <= run_nx;
					if (use_entry && (run_nx > pick_q)) begin
						found_q <= 1'b1;
						move_q  <= rd_move;
						state_q <= B_OUT;
					end else if ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q) begin
						state_q <= B_OUT;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= B_RD;
					end
				end
				B_OUT: begin
					if (out_load) begin
						cnt_q   <= '0;
						total_q <= '0;
						top_q   <= '0;
						tcnt_q  <= '0;
						drop_q  <= 1'b0;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/wrep_checker.sv
// Port-level checker for the weighted random entry picker, with its bind.
module wrep_checker import wrep_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input logic              found,
	input logic [MOVE_W-1:0] chosen_move,
	input logic              overflowed
);

	logic [2:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready && in_last;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + {2'b00, in_beat} - {2'b00, out_beat};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable({found, chosen_move, overflowed}))
		else $error("result beat changed while stalled");

	a_zero_move: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> chosen_move == '0)
		else $error("move code nonzero on empty result");

	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result beat without a pending last beat");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd4)
		else $error("too many sets outstanding");

endmodule

bind weighted_random_entry_picker wrep_checker u_wrep_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_last     (in_ch.last),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.found       (out_ch.found),
	.chosen_move (out_ch.chosen_move),
	.overflowed  (out_ch.overflowed)
);

// File: tb/weighted_random_entry_picker_test.sv
// Testbench for the weighted random entry picker: streamed candidate sets against a pick predictor.
module weighted_random_entry_picker_test;
	timeunit 1ns;
	timeprecision 1ps;
	import wrep_pkg::*;

	localparam int DRAIN_CYCLES = 250;
	localparam int STALL_LIMIT  = 4000;
	localparam int SEGMENT_BEATS = 325;

	typedef struct packed {
		logic              found;
		logic [MOVE_W-1:0] chosen_move;
		logic              overflowed;
	} pick_t;

	class picker_scoreboard;
		bit                 pick_mode;
		logic [MOVE_W-1:0]  set_moves[MAX_ENTRIES_DEF];
		logic [SCORE_W-1:0] set_scores[MAX_ENTRIES_DEF];
		int unsigned        set_size;
		int unsigned        score_sum;
		int unsigned        best_score;
		int unsigned        best_count;
		bit                 set_dropped;
		pick_t              expected_picks[$];
		int unsigned        mismatches;
		int unsigned        picks_checked;
		int unsigned        picks_found;
		int unsigned        picks_overflowed;
		int unsigned        beats_taken;

		function void note_candidate(logic [MOVE_W-1:0] move_code,
				logic signed [SCORE_IN_W-1:0] score, logic valid_mark, logic last,
				logic [RND_W-1:0] random_value);
			int unsigned weight;
			int unsigned pool;
			int unsigned pick;
			int unsigned run;
			pick_t       res;
			beats_taken++;
			if (valid_mark && score > 0) begin
				weight = 32'(score[SCORE_W-1:0]);
				if (set_size >= MAX_ENTRIES_DEF) begin
					set_dropped = 1'b1;
				end else begin
					set_moves[set_size]  = move_code;
					set_scores[set_size] = score[SCORE_W-1:0];
					set_size++;
					score_sum += weight;
					if (weight > best_score) begin
						best_score = weight;
						best_count = 1;
					end else if (weight == best_score) begin
						best_count++;
					end
				end
			end
			if (!last)
				return;
			res = '0;
			res.overflowed = set_dropped;
			pool = pick_mode ? best_score * best_count : score_sum;
			if (set_size != 0 && pool != 0) begin
				pick = random_value % pool;
				run = 0;
				for (int unsigned i = 0; i < set_size; i++) begin
					if (pick_mode && 32'(set_scores[i]) != best_score)
						continue;
					run += 32'(set_scores[i]);
					if (run > pick) begin
						res.found = 1'b1;
						res.chosen_move = set_moves[i];
						break;
					end
				end
			end
			expected_picks.push_back(res);
			set_size = 0;
			score_sum = 0;
			best_score = 0;
			best_count = 0;
			set_dropped = 1'b0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_pick(pick_t got);
			pick_t want;
			if (expected_picks.size() == 0) begin
				report($sformatf("result with no pick pending: found %b move %h overflow %b",
					got.found, got.chosen_move, got.overflowed));
				return;
			end
			want = expected_picks.pop_front();
			picks_checked++;
			if (want.found)
				picks_found++;
			if (want.overflowed)
				picks_overflowed++;
			if (got.found !== want.found || got.chosen_move !== want.chosen_move ||
					got.overflowed !== want.overflowed)
				report($sformatf("pick %0d: found %b/%b move %h/%h overflow %b/%b (got/want)",
					picks_checked, got.found, want.found, got.chosen_move, want.chosen_move,
					got.overflowed, want.overflowed));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	wrep_in_if  in_ch();
	wrep_out_if out_ch();

	picker_scoreboard pick_board = new();
	int unsigned      send_idle_pct;
	int unsigned      recv_idle_pct;
	int unsigned      quiet_cycles;

	weighted_random_entry_picker i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always #2 clk = ~clk;

	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && in_ch.valid && in_ch.ready)
			pick_board.note_candidate(in_ch.move_code, in_ch.score, in_ch.valid_mark,
				in_ch.last, in_ch.random_value);
		if (arst_n && out_ch.valid && out_ch.ready)
			pick_board.check_pick(pick_t'{out_ch.found, out_ch.chosen_move, out_ch.overflowed});
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_candidate(input logic [MOVE_W-1:0] move_code,
			input logic signed [SCORE_IN_W-1:0] score, input logic valid_mark,
			input logic last, input logic [RND_W-1:0] random_value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.move_code    <= move_code;
		in_ch.score        <= score;
		in_ch.valid_mark   <= valid_mark;
		in_ch.last         <= last;
		in_ch.random_value <= random_value;
		do
			@(posedge clk);
		while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic quiesce(input bit wait_tail);
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (pick_board.expected_picks.size() != 0)
			@(negedge clk);
		if (wait_tail)
			repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input bit mode);
		quiesce(1'b1);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		pick_board.pick_mode = mode;
	endtask

	task automatic send_random_set(output int unsigned counted);
		int unsigned               length;
		int unsigned               style;
		int unsigned               pick;
		logic signed [SCORE_IN_W-1:0] score;
		logic                      valid_mark;
		logic [RND_W-1:0]          random_value;
		counted = 0;
		pick = $urandom_range(99);
		if (pick < 78)
			length = $urandom_range(1, 12);
		else if (pick < 92)
			length = $urandom_range(13, 60);
		else
			length = $urandom_range(70, 100);
		style = $urandom_range(2);
		for (int unsigned n = 1; n <= length; n++) begin
			case (style)
				0: score = SCORE_IN_W'($urandom_range(1, 4));
				1: score = SCORE_IN_W'($urandom_range(1, 32767));
				default: score = SCORE_IN_W'($urandom_range(1, 300));
			endcase
			if ($urandom_range(99) < 10)
				score = ($urandom_range(4) == 0) ? 16'sd0 :
					SCORE_IN_W'(32'h8000 | $urandom_range(16'h7FFF));
			valid_mark = ($urandom_range(99) >= 8);
			random_value = ($urandom_range(9) < 7) ? $urandom : $urandom_range(100);
			send_candidate(MOVE_W'($urandom_range(16'hFFFF)), score, valid_mark, n == length,
				random_value);
			counted++;
		end
	endtask

	task automatic run_segment(input bit mode, input int unsigned paused_sets);
		int unsigned counted;
		int unsigned total;
		write_mode(mode);
		total = 0;
		while (total < SEGMENT_BEATS) begin
			if (paused_sets != 0) begin
				quiesce(1'b0);
				paused_sets--;
			end
			send_random_set(counted);
			total += counted;
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = 1'b0;
		in_ch.valid        = 1'b0;
		in_ch.move_code    = '0;
		in_ch.score        = '0;
		in_ch.valid_mark   = 1'b0;
		in_ch.last         = 1'b0;
		in_ch.random_value = '0;
		out_ch.ready       = 1'b0;
		quiet_cycles       = 0;
		send_idle_pct      = 13;
		recv_idle_pct      = 54;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_mode(1'b0);
		send_candidate(16'h1234, 16'sd5, 1'b0, 1'b1, 32'd0);
		send_candidate(16'hABCD, -16'sd1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_candidate(16'hFFFF, 16'sd32767, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h0001, 16'sh8000, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h0002, 16'sd0, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h0003, 16'sd1, 1'b0, 1'b0, 32'd0);
		send_candidate(16'h0000, 16'sd1, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_candidate(16'h0102, 16'sd10, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h0304, 16'sd20, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h0506, 16'sd30, 1'b1, 1'b1, 32'd0);
		send_candidate(16'h0102, 16'sd10, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h0304, 16'sd20, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h0506, 16'sd30, 1'b1, 1'b1, 32'd59);

		write_mode(1'b1);
		send_candidate(16'h1111, 16'sd9, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h2222, 16'sd3, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h3333, 16'sd9, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h4444, 16'sd9, 1'b1, 1'b1, 32'd5);
		send_candidate(16'h5555, 16'sd7, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h6666, 16'sd12, 1'b1, 1'b0, 32'd0);
		send_candidate(16'h7777, -16'sd5, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_candidate(16'h8888, 16'sd32767, 1'b1, 1'b1, 32'd123);
		send_candidate(16'h9999, 16'sd0, 1'b1, 1'b1, 32'd7);

		run_segment(1'b0, 0);
		run_segment(1'b1, 0);
		send_idle_pct = 54;
		recv_idle_pct = 13;
		run_segment(1'b1, 4);
		run_segment(1'b0, 0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_segment(1'b0, 0);
		run_segment(1'b1, 0);
		quiesce(1'b1);

		$display("Sent %0d candidate beats; checked %0d picks, %0d found, %0d with dropped entries,",
			pick_board.beats_taken, pick_board.picks_checked, pick_board.picks_found,
			pick_board.picks_overflowed);
		$display("over both pick modes with idling on either side, a paused sender and no idling.");
		if (pick_board.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
